// ===== hdl/pq16_pkg.sv =====
// ----------------------------------------------------------------------------
// pq16_pkg
// Shared types, palette constants and helpers for the 16-color quantizer.
// ----------------------------------------------------------------------------
package pq16_pkg;

    localparam int NUM_COLORS = 16;
    localparam int NUM_CHANS  = 3;
    localparam int SAMPLE_W   = 16;
    localparam int CHAN_W     = 8;
    localparam int PROD_W     = SAMPLE_W + CHAN_W;
    localparam int DOT_W      = 18;
    localparam int KEY_W      = 20;
    localparam int IDX_W      = 4;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    // bias that keeps the distance key non-negative: 2 * 3 * 255 * 255
    localparam int KEY_BIAS = 2 * NUM_CHANS * 255 * 255;

    // terminal palette, channel order red, green, blue
    localparam logic [CHAN_W-1:0] PALETTE [NUM_COLORS][NUM_CHANS] = '{
        '{8'd46,  8'd52,  8'd54 }, '{8'd204, 8'd0,   8'd0  },
        '{8'd78,  8'd154, 8'd6  }, '{8'd196, 8'd160, 8'd0  },
        '{8'd52,  8'd101, 8'd164}, '{8'd117, 8'd80,  8'd123},
        '{8'd6,   8'd152, 8'd154}, '{8'd211, 8'd215, 8'd207},
        '{8'd85,  8'd87,  8'd83 }, '{8'd239, 8'd41,  8'd41 },
        '{8'd138, 8'd226, 8'd52 }, '{8'd252, 8'd233, 8'd79 },
        '{8'd114, 8'd159, 8'd207}, '{8'd173, 8'd127, 8'd168},
        '{8'd52,  8'd226, 8'd226}, '{8'd238, 8'd238, 8'd236}
    };

    // one channel inside the divider pipeline
    typedef struct packed {
        logic [PROD_W-1:0] rem;
        logic [CHAN_W-1:0] quo;
        logic              sat;
    } t_div_lane;

    typedef t_div_lane [NUM_CHANS-1:0] t_div_pix;

    typedef logic [KEY_W-1:0] t_key;
    typedef t_key [NUM_COLORS-1:0] t_key_vec;

    // squared norm of a palette entry, evaluated at elaboration
    function automatic t_key pal_norm(input int idx);
        int r;
        int g;
        int b;
        r = int'(PALETTE[idx][0]);
        g = int'(PALETTE[idx][1]);
        b = int'(PALETTE[idx][2]);
        return KEY_W'(r * r + g * g + b * b);
    endfunction

endpackage

// ===== hdl/pq16_div_step.sv =====
// ----------------------------------------------------------------------------
// pq16_div_step
// One restoring-division stage: resolves one quotient bit on all channels.
// ----------------------------------------------------------------------------
module pq16_div_step
    import pq16_pkg::*;
#(
    parameter int BIT = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  t_div_pix            i_pix,
    input  logic [SAMPLE_W-1:0] i_divisor,
    output logic                o_valid,
    output t_div_pix            o_pix
);

    logic        r_valid;
    t_div_pix    r_pix;
    t_div_pix    n_pix;
    logic [PROD_W-1:0] shifted;

    // compare and subtract the shifted divisor on each channel
    always_comb begin
        shifted = {{CHAN_W{1'b0}}, i_divisor} << BIT;
        for (int l = 0; l < NUM_CHANS; l++) begin
            n_pix[l] = i_pix[l];
            if (i_pix[l].rem >= shifted) begin
                n_pix[l].rem      = i_pix[l].rem - shifted;
                n_pix[l].quo[BIT] = 1'b1;
            end
        end
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_pix <= n_pix;
        end
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;

endmodule

// ===== hdl/pq16_dist.sv =====
// ----------------------------------------------------------------------------
// pq16_dist
// Distance key per palette entry: |p|^2 - 2 * dot(pixel, p), biased positive.
// ----------------------------------------------------------------------------
module pq16_dist
    import pq16_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_div_pix i_pix,
    output logic     o_valid,
    output t_key_vec o_keys
);

    logic              r_valid;
    t_key_vec          r_keys;
    t_key_vec          n_keys;
    logic [CHAN_W-1:0] chan [NUM_CHANS];
    logic [DOT_W-1:0]  dot;

    // saturate the quotient, then form one key per palette entry
    always_comb begin
        for (int l = 0; l < NUM_CHANS; l++) begin
            chan[l] = i_pix[l].sat ? CHAN_MAX : i_pix[l].quo;
        end
        dot = '0;
        for (int c = 0; c < NUM_COLORS; c++) begin
            dot = DOT_W'(chan[0]) * DOT_W'(PALETTE[c][0])
                + DOT_W'(chan[1]) * DOT_W'(PALETTE[c][1])
                + DOT_W'(chan[2]) * DOT_W'(PALETTE[c][2]);
            n_keys[c] = KEY_W'(KEY_BIAS) + pal_norm(c) - KEY_W'({dot, 1'b0});
        end
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_keys <= n_keys;
        end
    end

    assign o_valid = r_valid;
    assign o_keys  = r_keys;

endmodule

// ===== hdl/pq16_argmin.sv =====
// ----------------------------------------------------------------------------
// pq16_argmin
// Two-stage minimum search over the 16 keys, lowest index wins on ties.
// ----------------------------------------------------------------------------
module pq16_argmin
    import pq16_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_en,
    input  logic             i_valid,
    input  t_key_vec         i_keys,
    output logic [1:0]       o_valid,
    output logic [IDX_W-1:0] o_color_index
);

    localparam int GROUPS = 4;
    localparam int GROUP_SIZE = NUM_COLORS / GROUPS;

    typedef struct packed {
        t_key             key;
        logic [IDX_W-1:0] idx;
    } t_cand;

    logic             r_valid_a;
    logic             r_valid_b;
    t_cand            r_grp [GROUPS];
    t_cand            n_grp [GROUPS];
    logic [IDX_W-1:0] r_idx;
    t_cand            n_best;

    // first stage: best of each group of four
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            n_grp[g].key = i_keys[g * GROUP_SIZE];
            n_grp[g].idx = IDX_W'(g * GROUP_SIZE);
            for (int j = 1; j < GROUP_SIZE; j++) begin
                if (i_keys[g * GROUP_SIZE + j] < n_grp[g].key) begin
                    n_grp[g].key = i_keys[g * GROUP_SIZE + j];
                    n_grp[g].idx = IDX_W'(g * GROUP_SIZE + j);
                end
            end
        end
    end

    // second stage: best of the group winners
    always_comb begin
        n_best = r_grp[0];
        for (int g = 1; g < GROUPS; g++) begin
            if (r_grp[g].key < n_best.key) begin
                n_best = r_grp[g];
            end
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            if (i_en[0]) begin
                r_valid_a <= i_valid;
            end
            if (i_en[1]) begin
                r_valid_b <= r_valid_a;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (i_en[0] && i_valid) begin
            r_grp <= n_grp;
        end
        if (i_en[1] && r_valid_a) begin
            r_idx <= n_best.idx;
        end
    end

    assign o_valid       = {r_valid_b, r_valid_a};
    assign o_color_index = r_idx;

endmodule

// ===== hdl/rgb_to_palette16_quantizer.sv =====
// ----------------------------------------------------------------------------
// rgb_to_palette16_quantizer
// Maps an RGB pixel to the nearest of 16 fixed terminal palette colors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one pixel request of three
//   16-bit samples. Each channel is scaled to sample*255/max_sample_value
//   (truncated, saturated at 255, a zero divisor counts as one), then the
//   palette index with the smallest squared distance is returned on the
//   output channel (o_valid / i_stall), lowest index on ties.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes the maximum
//   sample value; ready is always high. Write it only while the pipe is empty.
//   The pipe holds 12 register stages: one scaling stage, eight
//   restoring-division stages (one quotient bit each), one distance-key
//   stage and two min-search stages. Throughput is one pixel per clock
//   while no downstream stall holds the output.
//   A downstream stall holds the output; stages behind it keep filling any
//   empty slots, and o_stall rises only when all 12 stages are occupied.
//   Reset empties the pipe and sets the maximum sample value to 255.
// ----------------------------------------------------------------------------
module rgb_to_palette16_quantizer
    import pq16_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [SAMPLE_W-1:0] i_red,
    input  logic [SAMPLE_W-1:0] i_green,
    input  logic [SAMPLE_W-1:0] i_blue,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [IDX_W-1:0]    o_color_index,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [SAMPLE_W-1:0] i_cfg_data
);

    localparam int DIV_STAGES = CHAN_W;
    localparam int NUM_STAGES = DIV_STAGES + 4;

    logic [NUM_STAGES-1:0] stage_valid;
    logic [NUM_STAGES-1:0] stage_en;

    logic [SAMPLE_W-1:0]   r_divisor;
    logic                  r_s0_valid;
    t_div_pix              r_s0_pix;
    t_div_pix              n_s0_pix;

    logic [DIV_STAGES:0]   div_valid;
    t_div_pix              div_pix [DIV_STAGES+1];

    logic                  dist_valid;
    t_key_vec              dist_keys;
    logic [1:0]            min_valid;

    // sample * 255 and the overflow check against divisor * 256
    function automatic t_div_lane lane_init(
        input logic [SAMPLE_W-1:0] s,
        input logic [SAMPLE_W-1:0] d
    );
        t_div_lane lane;
        lane.rem = {s, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, s};
        lane.quo = '0;
        lane.sat = lane.rem[PROD_W-1:CHAN_W] >= d;
        return lane;
    endfunction

    // configuration register, stored as the effective divisor
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divisor <= SAMPLE_W'(255);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_divisor <= (i_cfg_data == '0) ? SAMPLE_W'(1) : i_cfg_data;
        end
    end

    // stage enables: a stage loads when empty or when the next one moves
    always_comb begin
        stage_en[NUM_STAGES-1] = !stage_valid[NUM_STAGES-1] || !i_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !stage_valid[k] || stage_en[k+1];
        end
    end

    assign o_stall = !stage_en[0];

    // input stage: scale product and saturation flag
    always_comb begin
        n_s0_pix[0] = lane_init(i_red,   r_divisor);
        n_s0_pix[1] = lane_init(i_green, r_divisor);
        n_s0_pix[2] = lane_init(i_blue,  r_divisor);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (stage_en[0]) begin
            r_s0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[0] && i_valid) begin
            r_s0_pix <= n_s0_pix;
        end
    end

    // divider pipeline, most significant quotient bit first
    assign div_valid[0] = r_s0_valid;
    assign div_pix[0]   = r_s0_pix;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        pq16_div_step #(
            .BIT (DIV_STAGES - 1 - g)
        ) u_div_step (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (stage_en[g+1]),
            .i_valid   (div_valid[g]),
            .i_pix     (div_pix[g]),
            .i_divisor (r_divisor),
            .o_valid   (div_valid[g+1]),
            .o_pix     (div_pix[g+1])
        );
    end

    // distance keys
    pq16_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (stage_en[DIV_STAGES+1]),
        .i_valid (div_valid[DIV_STAGES]),
        .i_pix   (div_pix[DIV_STAGES]),
        .o_valid (dist_valid),
        .o_keys  (dist_keys)
    );

    // minimum search and output register
    pq16_argmin u_argmin (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (stage_en[NUM_STAGES-1:NUM_STAGES-2]),
        .i_valid       (dist_valid),
        .i_keys        (dist_keys),
        .o_valid       (min_valid),
        .o_color_index (o_color_index)
    );

    // stage occupancy
    assign stage_valid = {min_valid, dist_valid, div_valid};
    assign o_valid     = min_valid[1];

endmodule

// ===== hdl/pq16_checker.sv =====
// ----------------------------------------------------------------------------
// pq16_checker
// Port-level checks for the quantizer, bound to the top level.
// ----------------------------------------------------------------------------
module pq16_checker
    import pq16_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_stall,
    input logic             o_valid,
    input logic             i_stall,
    input logic [IDX_W-1:0] o_color_index
);

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // back-pressure upstream only when the output itself is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output is free");

    // a blocked result request stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_color_index)))
        else $error("stalled result changed or dropped");

endmodule

bind rgb_to_palette16_quantizer pq16_checker u_pq16_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_color_index (o_color_index)
);
